// ===== src/indexed_doubly_linked_list_macros.svh =====
// ---------------------------------------------------------------------------
// Indexed doubly linked list assertion macros
// Shared concurrent assertion forms for the list controller.
// ---------------------------------------------------------------------------
`ifndef INDEXED_DOUBLY_LINKED_LIST_MACROS_SVH
`define INDEXED_DOUBLY_LINKED_LIST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IDLL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("idll assertion failed");

// Next-cycle implication, disabled during reset.
`define IDLL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("idll assertion failed");

`endif

// ===== src/idll_pkg.sv =====
// ---------------------------------------------------------------------------
// Indexed doubly linked list package
// Request and status codes, node limit and the layout of one link entry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package idll_pkg;

    localparam int unsigned MAX_NODES = 65535;
    localparam logic [16:0] NODE_LIMIT =
        17'((MAX_NODES < 65535) ? MAX_NODES : 65535);

    localparam logic [1:0] REQ_INS_RIGHT = 2'd0;
    localparam logic [1:0] REQ_INS_LEFT  = 2'd1;
    localparam logic [1:0] REQ_REMOVE    = 2'd2;
    localparam logic [1:0] REQ_WALK      = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_IGNORED = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_ABSENT  = 2'd3;

    typedef struct packed {
        logic        member;
        logic [15:0] prev;
        logic [15:0] next;
    } idll_entry_t;

    localparam int unsigned ENTRY_W = $bits(idll_entry_t);
    localparam int unsigned DEPTH   = 65536;

endpackage

// ===== src/idll_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module idll_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/indexed_doubly_linked_list.sv =====
// ---------------------------------------------------------------------------
// Indexed doubly linked list
// Linked order of numbered nodes kept in one link RAM, with insert, remove
// and walk transactions.
// ---------------------------------------------------------------------------
// One transaction is taken when start is high and busy is low. A walk step
// reads the cursor's entry, then the next node's; an insert writes the
// reference and fresh entries and any linked neighbour; a remove clears the
// entry and fixes one or two neighbours. An absent node, a lack of node
// numbers or an ignored removal ends the request after the first read. The
// link RAM has one read and one write port with a registered read, so each
// neighbour link is read and then written back. The result appears for exactly
// one cycle with done high and cannot be held off. After reset busy stays
// high for one cycle while node 1 is written; node numbers are handed out
// in order, so entries at or above the next free number are treated as absent.
`timescale 1ns / 1ps

module indexed_doubly_linked_list
    import idll_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [15:0] ref_node,
    output logic        done,
    output logic [15:0] node_id,
    output logic        is_last,
    output logic [1:0]  status
);

`include "indexed_doubly_linked_list_macros.svh"

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_RD1    = 3'd2;
    localparam logic [2:0] S_WALK2  = 3'd3;
    localparam logic [2:0] S_WRFRSH = 3'd4;
    localparam logic [2:0] S_FIXRD  = 3'd5;
    localparam logic [2:0] S_FIXWR  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  type_reg, type_next;
    logic [15:0] ref_reg, ref_next;
    logic [15:0] head_reg, head_next;
    logic [16:0] nfi_reg, nfi_next;
    logic [15:0] cursor_reg, cursor_next;
    logic [15:0] rdaddr_reg;
    logic [15:0] fresh_addr_reg, fresh_addr_next;
    idll_entry_t fresh_ent_reg, fresh_ent_next;
    logic        fixa_valid_reg, fixa_valid_next;
    logic [15:0] fixa_addr_reg, fixa_addr_next;
    logic        fixa_isnext_reg, fixa_isnext_next;
    logic [15:0] fixa_val_reg, fixa_val_next;
    logic        fixb_valid_reg, fixb_valid_next;
    logic [15:0] fixb_addr_reg, fixb_addr_next;
    logic        fixb_isnext_reg, fixb_isnext_next;
    logic [15:0] fixb_val_reg, fixb_val_next;
    logic [15:0] res_node_reg, res_node_next;
    logic        res_last_reg, res_last_next;
    logic [1:0]  res_stat_reg, res_stat_next;
    logic        done_reg, done_next;

    logic        we;
    logic [15:0] waddr;
    idll_entry_t wdata;
    logic [15:0] raddr;
    logic [ENTRY_W-1:0] rdata_raw;
    idll_entry_t ent;
    logic        ent_member;
    logic [15:0] walk_node;
    logic [15:0] fresh_id;

    idll_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_links (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    always_comb
    begin
        if (rdaddr_reg == 16'd0)
        begin
            ent = '0;
        end
        else
        begin
            ent = idll_entry_t'(rdata_raw);
        end
        ent_member = ent.member && ({1'b0, rdaddr_reg} < nfi_reg)
                     && (rdaddr_reg != 16'd0);
        walk_node = ((cursor_reg == 16'd0) || !ent_member) ? head_reg : ent.next;
        fresh_id = nfi_reg[15:0];
    end

    always_comb
    begin
        state_next       = state_reg;
        type_next        = type_reg;
        ref_next         = ref_reg;
        head_next        = head_reg;
        nfi_next         = nfi_reg;
        cursor_next      = cursor_reg;
        fresh_addr_next  = fresh_addr_reg;
        fresh_ent_next   = fresh_ent_reg;
        fixa_valid_next  = fixa_valid_reg;
        fixa_addr_next   = fixa_addr_reg;
        fixa_isnext_next = fixa_isnext_reg;
        fixa_val_next    = fixa_val_reg;
        fixb_valid_next  = fixb_valid_reg;
        fixb_addr_next   = fixb_addr_reg;
        fixb_isnext_next = fixb_isnext_reg;
        fixb_val_next    = fixb_val_reg;
        res_node_next    = res_node_reg;
        res_last_next    = res_last_reg;
        res_stat_next    = res_stat_reg;
        done_next        = 1'b0;
        we               = 1'b0;
        waddr            = 16'd0;
        wdata            = '0;
        raddr            = 16'd0;

        case (state_reg)
            S_INIT:
            begin
                we          = 1'b1;
                waddr       = 16'd1;
                wdata       = '{member: 1'b1, prev: 16'd0, next: 16'd0};
                state_next  = S_IDLE;
            end
            S_IDLE:
            begin
                raddr = (req_type == REQ_WALK) ? cursor_reg : ref_node;
                if (start)
                begin
                    type_next  = req_type;
                    ref_next   = ref_node;
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                raddr         = walk_node;
                res_node_next = 16'd0;
                res_last_next = 1'b0;
                res_stat_next = STAT_OK;
                if (type_reg == REQ_WALK)
                begin
                    if (walk_node == 16'd0)
                    begin
                        res_last_next = 1'b1;
                        cursor_next   = 16'd0;
                        done_next     = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_WALK2;
                    end
                end
                else if (!ent_member)
                begin
                    res_stat_next = STAT_ABSENT;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (type_reg == REQ_REMOVE)
                begin
                    if ((ent.prev == 16'd0) && (ent.next == 16'd0))
                    begin
                        res_stat_next = STAT_IGNORED;
                        done_next     = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        we              = 1'b1;
                        waddr           = ref_reg;
                        wdata           = '0;
                        res_node_next   = ref_reg;
                        fixa_valid_next = 1'b1;
                        state_next      = S_FIXRD;
                        if (ent.prev != 16'd0)
                        begin
                            fixa_addr_next   = ent.prev;
                            fixa_isnext_next = 1'b1;
                            fixa_val_next    = ent.next;
                            fixb_valid_next  = (ent.next != 16'd0);
                            fixb_addr_next   = ent.next;
                            fixb_isnext_next = 1'b0;
                            fixb_val_next    = ent.prev;
                        end
                        else
                        begin
                            head_next        = ent.next;
                            fixa_addr_next   = ent.next;
                            fixa_isnext_next = 1'b0;
                            fixa_val_next    = 16'd0;
                            fixb_valid_next  = 1'b0;
                        end
                    end
                end
                else if (nfi_reg > NODE_LIMIT)
                begin
                    res_stat_next = STAT_FULL;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    we               = 1'b1;
                    waddr            = ref_reg;
                    res_node_next    = fresh_id;
                    fresh_addr_next  = fresh_id;
                    nfi_next         = nfi_reg + 17'd1;
                    fixb_valid_next  = 1'b0;
                    state_next       = S_WRFRSH;
                    if (type_reg == REQ_INS_RIGHT)
                    begin
                        wdata            = '{member: 1'b1, prev: ent.prev, next: fresh_id};
                        fresh_ent_next   = '{member: 1'b1, prev: ref_reg, next: ent.next};
                        fixa_valid_next  = (ent.next != 16'd0);
                        fixa_addr_next   = ent.next;
                        fixa_isnext_next = 1'b0;
                        fixa_val_next    = fresh_id;
                    end
                    else
                    begin
                        wdata            = '{member: 1'b1, prev: fresh_id, next: ent.next};
                        fresh_ent_next   = '{member: 1'b1, prev: ent.prev, next: ref_reg};
                        fixa_valid_next  = (ent.prev != 16'd0);
                        fixa_addr_next   = ent.prev;
                        fixa_isnext_next = 1'b1;
                        fixa_val_next    = fresh_id;
                        if (ent.prev == 16'd0)
                        begin
                            head_next = fresh_id;
                        end
                    end
                end
            end
            S_WALK2:
            begin
                res_node_next = rdaddr_reg;
                res_last_next = (ent.next == 16'd0);
                res_stat_next = STAT_OK;
                cursor_next   = (ent.next == 16'd0) ? 16'd0 : rdaddr_reg;
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end
            S_WRFRSH:
            begin
                we    = 1'b1;
                waddr = fresh_addr_reg;
                wdata = fresh_ent_reg;
                if (fixa_valid_reg)
                begin
                    state_next = S_FIXRD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIXRD:
            begin
                raddr      = fixa_addr_reg;
                state_next = S_FIXWR;
            end
            S_FIXWR:
            begin
                we    = 1'b1;
                waddr = fixa_addr_reg;
                wdata = ent;
                if (fixa_isnext_reg)
                begin
                    wdata.next = fixa_val_reg;
                end
                else
                begin
                    wdata.prev = fixa_val_reg;
                end
                if (fixb_valid_reg)
                begin
                    fixa_addr_next   = fixb_addr_reg;
                    fixa_isnext_next = fixb_isnext_reg;
                    fixa_val_next    = fixb_val_reg;
                    fixb_valid_next  = 1'b0;
                    state_next       = S_FIXRD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            head_reg       <= 16'd1;
            nfi_reg        <= 17'd2;
            cursor_reg     <= 16'd0;
            fixa_valid_reg <= 1'b0;
            fixb_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            nfi_reg        <= nfi_next;
            cursor_reg     <= cursor_next;
            fixa_valid_reg <= fixa_valid_next;
            fixb_valid_reg <= fixb_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg        <= type_next;
        ref_reg         <= ref_next;
        rdaddr_reg      <= raddr;
        fresh_addr_reg  <= fresh_addr_next;
        fresh_ent_reg   <= fresh_ent_next;
        fixa_addr_reg   <= fixa_addr_next;
        fixa_isnext_reg <= fixa_isnext_next;
        fixa_val_reg    <= fixa_val_next;
        fixb_addr_reg   <= fixb_addr_next;
        fixb_isnext_reg <= fixb_isnext_next;
        fixb_val_reg    <= fixb_val_next;
        res_node_reg    <= res_node_next;
        res_last_reg    <= res_last_next;
        res_stat_reg    <= res_stat_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign node_id = res_node_reg;
    assign is_last = res_last_reg;
    assign status  = res_stat_reg;

    // A transaction always completes back in the idle state.
    `IDLL_ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy)
    // An accepted transaction makes the block busy once the state register takes it.
    `IDLL_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // Any error status carries no node number.
    `IDLL_ASSERT_IMPL(a_err_zero, clk, rst_n, done && (status != STAT_OK), node_id == 16'd0)
    // The tail flag only comes with a successful result.
    `IDLL_ASSERT_IMPL(a_last_ok, clk, rst_n, done && is_last, status == STAT_OK)

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// Indexed doubly linked list testbench
// Drives insert, remove and walk transactions with random idling and checks
// every result against a behavioural model of the linked order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import idll_pkg::*;

    typedef struct packed {
        logic [15:0] node;
        logic        last;
        logic [1:0]  stat;
    } list_result_t;

    class list_scoreboard;
        logic [15:0]  prev_link [int];
        logic [15:0]  next_link [int];
        bit           present [int];
        logic [15:0]  head;
        logic [16:0]  fresh_id;
        logic [15:0]  cursor;
        list_result_t pending [$];
        int           mismatches;

        function new();
            present[1] = 1'b1;
            head = 16'd1;
            fresh_id = 17'd2;
            cursor = 16'd0;
            mismatches = 0;
        endfunction

        function logic [15:0] nxt(logic [15:0] n);
            return next_link.exists(n) ? next_link[n] : 16'd0;
        endfunction

        function logic [15:0] prv(logic [15:0] n);
            return prev_link.exists(n) ? prev_link[n] : 16'd0;
        endfunction

        function bit member(logic [15:0] n);
            return present.exists(n) && present[n];
        endfunction

        function void note_request(logic [1:0] kind, logic [15:0] ref_id);
            list_result_t r;
            logic [15:0]  p;
            logic [15:0]  n;
            logic [15:0]  f;
            r = '0;
            if (kind == REQ_WALK)
            begin
                if (cursor == 16'd0 || !member(cursor))
                    n = head;
                else
                    n = nxt(cursor);
                r.node = n;
                r.last = (nxt(n) == 16'd0);
                cursor = r.last ? 16'd0 : n;
                r.stat = STAT_OK;
            end
            else if (!member(ref_id))
            begin
                r.stat = STAT_ABSENT;
            end
            else if (kind == REQ_REMOVE)
            begin
                p = prv(ref_id);
                n = nxt(ref_id);
                if (p == 16'd0 && n == 16'd0)
                begin
                    r.stat = STAT_IGNORED;
                end
                else
                begin
                    if (p != 16'd0)
                        next_link[p] = n;
                    else
                        head = n;
                    if (n != 16'd0)
                        prev_link[n] = p;
                    prev_link[ref_id] = 16'd0;
                    next_link[ref_id] = 16'd0;
                    present[ref_id] = 1'b0;
                    r.node = ref_id;
                    r.stat = STAT_OK;
                end
            end
            else if (fresh_id > NODE_LIMIT)
            begin
                r.stat = STAT_FULL;
            end
            else
            begin
                f = fresh_id[15:0];
                if (kind == REQ_INS_RIGHT)
                begin
                    n = nxt(ref_id);
                    next_link[ref_id] = f;
                    prev_link[f] = ref_id;
                    next_link[f] = n;
                    if (n != 16'd0)
                        prev_link[n] = f;
                end
                else
                begin
                    p = prv(ref_id);
                    prev_link[ref_id] = f;
                    next_link[f] = ref_id;
                    prev_link[f] = p;
                    if (p != 16'd0)
                        next_link[p] = f;
                    else
                        head = f;
                end
                present[f] = 1'b1;
                fresh_id = fresh_id + 17'd1;
                r.node = f;
                r.stat = STAT_OK;
            end
            pending.push_back(r);
        endfunction

        function void check_result(list_result_t got);
            list_result_t exp_r;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: node %0d last %0d status %0d",
                             got.node, got.last, got.stat);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Mismatch: expected node %0d last %0d status %0d, ",
                              "got node %0d last %0d status %0d"},
                             exp_r.node, exp_r.last, exp_r.stat,
                             got.node, got.last, got.stat);
            end
        endfunction

        function int live_pick();
            int keys [$];
            foreach (present[k])
                if (present[k])
                    keys.push_back(k);
            return keys[$urandom_range(keys.size() - 1)];
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  req_type = '0;
    logic [15:0] ref_node = '0;
    logic        done;
    logic [15:0] node_id;
    logic        is_last;
    logic [1:0]  status;

    list_scoreboard sb = new();
    bit             idle_enable = 1'b1;

    always #1 clk = ~clk;

    indexed_doubly_linked_list i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req_type (req_type),
        .ref_node (ref_node),
        .done     (done),
        .node_id  (node_id),
        .is_last  (is_last),
        .status   (status)
    );

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result({node_id, is_last, status});
    end

    // The start strobe stays high between back-to-back transactions; it is
    // dropped only before idling and by the caller before a pause.
    task automatic issue(input logic [1:0] kind, input logic [15:0] ref_id);
        int gap;
        if (idle_enable && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(17, 1);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req_type <= kind;
        ref_node <= ref_id;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(kind, ref_id);
    endtask

    task automatic random_request();
        int          sel;
        logic [1:0]  kind;
        logic [15:0] r;
        kind = 2'($urandom_range(3));
        sel = $urandom_range(9);
        if (sel < 7)
            r = 16'(sb.live_pick());
        else if (sel == 7)
            r = 16'($urandom);
        else if (sel == 8)
            r = 16'd0;
        else
            r = 16'hFFFF;
        if (kind == REQ_REMOVE && sb.present.size() < 4 && $urandom_range(1))
            kind = REQ_INS_RIGHT;
        issue(kind, r);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        issue(REQ_WALK, 16'd0);
        issue(REQ_REMOVE, 16'd1);
        issue(REQ_INS_RIGHT, 16'd0);
        issue(REQ_REMOVE, 16'hFFFF);
        issue(REQ_INS_RIGHT, 16'd1);
        issue(REQ_INS_LEFT, 16'd1);
        issue(REQ_INS_LEFT, 16'd3);
        issue(REQ_INS_RIGHT, 16'd2);
        issue(REQ_INS_LEFT, 16'hFFFF);
        issue(REQ_WALK, 16'hFFFF);
        issue(REQ_WALK, 16'd0);
        issue(REQ_REMOVE, 16'd1);
        issue(REQ_WALK, 16'd0);
        issue(REQ_WALK, 16'd0);
        issue(REQ_WALK, 16'd0);
        issue(REQ_WALK, 16'd0);
        issue(REQ_REMOVE, 16'd4);
        issue(REQ_REMOVE, 16'd4);
        issue(REQ_WALK, 16'd0);
        issue(REQ_INS_RIGHT, 16'd5);
        issue(REQ_INS_RIGHT, 16'd2);
        repeat (600)
            random_request();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        repeat (600)
            random_request();
        idle_enable = 1'b0;
        repeat (400)
            random_request();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== indexed_doubly_linked_list.f =====
+incdir+src
src/idll_pkg.sv
src/idll_ram.sv
src/indexed_doubly_linked_list.sv
tb/tb_top.sv
